// ===== rtl/crc16_byte_engine_unit_macros.svh =====
// ----------------------------------------------------------------------------
// crc16_byte_engine_unit_macros
// Assertion macros shared by the CRC-16 byte engine RTL.
// ----------------------------------------------------------------------------
`ifndef CRC16_BYTE_ENGINE_UNIT_MACROS_SVH
`define CRC16_BYTE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CRC16BE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRC16BE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/crc16be_pkg.sv =====
// ----------------------------------------------------------------------------
// crc16be_pkg
// Shared types and constants of the CRC-16 byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package crc16be_pkg;

  localparam int CRC_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W = 8;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_POLYNOMIAL  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 8'd2;

  // Reset values of the configuration registers.
  localparam logic [CRC_W-1:0] POLY_RESET  = 16'h1021;
  localparam logic [CRC_W-1:0] START_RESET = 16'h0000;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [CRC_W-1:0] polynomial;
    logic             lsb_first;
    logic [CRC_W-1:0] start_value;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/crc16be_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// crc16be_cfg_regs
// Configuration register bank: polynomial, bit order and start value.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16be_cfg_regs
  import crc16be_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CRC_W-1:0]     cfg_wdata,
  output cfg_t                      cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode a write; indexes past the last register are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      if (cfg_index == CFG_POLYNOMIAL) begin
        cfg_nxt.polynomial = cfg_wdata;
      end else if (cfg_index == CFG_LSB_FIRST) begin
        cfg_nxt.lsb_first = cfg_wdata[0];
      end else if (cfg_index == CFG_START_VALUE) begin
        cfg_nxt.start_value = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.polynomial  <= POLY_RESET;
      cfg_r.lsb_first   <= 1'b0;
      cfg_r.start_value <= START_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/crc16be_fold.sv =====
// ----------------------------------------------------------------------------
// crc16be_fold
// Folds one byte into a CRC-16 value: eight unrolled XOR-shift steps.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16be_fold
  import crc16be_pkg::*;
(
  input  wire logic [CRC_W-1:0]  crc_i,
  input  wire logic [BYTE_W-1:0] data_i,
  input  wire logic [CRC_W-1:0]  poly_i,
  input  wire logic              lsb_first_i,
  output logic      [CRC_W-1:0]  crc_o
);

  logic [CRC_W-1:0] rpoly;
  logic [CRC_W-1:0] crc_msb;
  logic [CRC_W-1:0] crc_lsb;

  // Bit-reversed polynomial for the right-shifting form.
  always_comb begin
    for (int k = 0; k < CRC_W; k++) begin
      rpoly[k] = poly_i[CRC_W-1-k];
    end
  end

  // MSB-first: data bit 7 down to 0 against register bit 15.
  always_comb begin
    logic fb;
    crc_msb = crc_i;
    for (int b = BYTE_W - 1; b >= 0; b--) begin
      fb      = crc_msb[CRC_W-1] ^ data_i[b];
      crc_msb = {crc_msb[CRC_W-2:0], 1'b0} ^ (fb ? poly_i : '0);
    end
  end

  // LSB-first: data bit 0 up to 7 against register bit 0.
  always_comb begin
    logic fb;
    crc_lsb = crc_i;
    for (int b = 0; b < BYTE_W; b++) begin
      fb      = crc_lsb[0] ^ data_i[b];
      crc_lsb = {1'b0, crc_lsb[CRC_W-1:1]} ^ (fb ? rpoly : '0);
    end
  end

  assign crc_o = lsb_first_i ? crc_lsb : crc_msb;

endmodule

`default_nettype wire

// ===== rtl/crc16_byte_engine_unit.sv =====
// A byte is captured in the input register, then folded into the CRC register on out_tdata.
// Throughput: one byte per cycle unless stalled; CRC feeds back via one eight-step fold.
// A stalled result holds while the input register takes one more byte.
// Reset (rst_n low, synchronous): pipeline empty, CRC register zero,
// polynomial 0x1021, MSB first, start value zero.
// ----------------------------------------------------------------------------
// crc16_byte_engine_unit
// Configurable byte-wide CRC-16 engine with stream ports.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_byte_engine_unit
  import crc16be_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input request channel.
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]           in_tuser,   // [0] first_byte
  // Result channel.
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic      [15:0]          out_tdata,  // [15:0] crc_value
  // Configuration write port.
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CRC_W-1:0]     cfg_wdata
);

  cfg_t cfg;

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_data_r;
  logic              in_first_r;
  logic              out_valid_r;
  logic [CRC_W-1:0]  crc_r;
  logic [CRC_W-1:0]  crc_nxt;
  logic [CRC_W-1:0]  crc_base;
  logic              load;
  logic              in_acc;
  logic              out_acc;

  crc16be_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Handshake: the result stage loads when it is empty or being drained.
  assign out_acc   = out_valid_r && out_tready;
  assign load      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || load;
  assign in_acc    = in_tvalid && in_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r  <= in_tdata;
      in_first_r <= in_tuser[0];
    end
  end

  // A first byte restarts from the start value.
  assign crc_base = in_first_r ? cfg.start_value : crc_r;

  crc16be_fold u_fold (
    .crc_i       (crc_base),
    .data_i      (in_data_r),
    .poly_i      (cfg.polynomial),
    .lsb_first_i (cfg.lsb_first),
    .crc_o       (crc_nxt)
  );

  // CRC register doubles as the result register; it only changes on a load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        crc_r <= crc_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = crc_r;

  // Checks on the pipeline control.
  `include "crc16_byte_engine_unit_macros.svh"

  `CRC16BE_ASSERT_NEXT(a_load_shows_result, load, out_tvalid, "result missing after load")
  `CRC16BE_ASSERT_NEXT(a_drain_empties, out_acc && !load, !out_tvalid, "result repeated")
  `CRC16BE_ASSERT_NOW(a_stall_only_when_full, !in_tready,
    in_valid_r && out_valid_r && !out_tready, "input stalled without backpressure")

endmodule

`default_nettype wire
